>>> hw/rtl/swtm_pkg.sv
// Package for the sliding window trimmed mean unit.
// Holds field widths and the command and status structs shared by the
// controller, the datapath and the top level. Depends on nothing.
`default_nettype none

package swtm_pkg;

  localparam int SAMPLE_W = 24;
  localparam int FILL_W   = 5;
  localparam int OUT_DATA_W = 32;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan;
    logic trim;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic valid_now;
    logic scan_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/swtm_ctrl.sv
// Controller state machine of the sliding window trimmed mean unit.
// Sequences load, window scan, trim, serial division and result hand-off.
// Depends on swtm_pkg for the command and status structs.
`default_nettype none

module swtm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire swtm_pkg::status_t status,
  output swtm_pkg::cmd_t        cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.valid_now) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          cmd.trim   = 1'b1;
          state_next = ST_DIV;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/swtm_dp.sv
// Datapath of the sliding window trimmed mean unit.
// Window memory, scan accumulators, serial divider and output register.
// Depends on swtm_pkg; driven by swtm_ctrl through cmd_t and status_t.
`default_nettype none

module swtm_dp #(
  parameter int MIN_SAMPLES  = 8,
  parameter int WINDOW_DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire swtm_pkg::cmd_t                    cmd,
  output swtm_pkg::status_t                      status,
  input  wire logic signed [swtm_pkg::SAMPLE_W-1:0] sample,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output logic signed [swtm_pkg::SAMPLE_W-1:0]   res_mean,
  output logic                                   res_mean_valid,
  output logic [swtm_pkg::FILL_W-1:0]            res_fill
);

  localparam int SW     = swtm_pkg::SAMPLE_W;
  localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = SW + $clog2(WINDOW_DEPTH) + 1;
  localparam int DCNT_W = $clog2(SUM_W + 1);

  logic signed [SW-1:0] window_mem [WINDOW_DEPTH];
  logic signed [SW-1:0] rd_data;
  logic [ADDR_W-1:0]    write_slot;
  logic [CNT_W-1:0]     held_count;
  logic [CNT_W-1:0]     issue_cnt;
  logic                 rd_pend;
  logic signed [SUM_W-1:0] sum;
  logic signed [SW-1:0]    hi;
  logic signed [SW-1:0]    lo;
  logic signed [SUM_W-1:0] trimmed;
  logic [SUM_W-1:0]     quot;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     divisor;
  logic [CNT_W:0]       rem_shift;
  logic                 rem_ge;
  logic [DCNT_W-1:0]    div_cnt;
  logic                 neg;
  logic [SUM_W-1:0]     signed_quot;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      window_mem[write_slot] <= sample;
    end
    rd_data <= window_mem[issue_cnt[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      held_count <= '0;
    end else if (cmd.load) begin
      write_slot <= (write_slot == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : write_slot + 1'b1;
      if (held_count != CNT_W'(WINDOW_DEPTH)) begin
        held_count <= held_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      rd_pend   <= 1'b0;
    end else if (cmd.scan_start) begin
      issue_cnt <= '0;
      rd_pend   <= 1'b0;
    end else if (cmd.scan) begin
      rd_pend <= (issue_cnt != held_count);
      if (issue_cnt != held_count) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      sum <= '0;
      hi  <= {1'b1, {(SW-1){1'b0}}};
      lo  <= {1'b0, {(SW-1){1'b1}}};
    end else if (cmd.scan && rd_pend) begin
      sum <= sum + {{(SUM_W-SW){rd_data[SW-1]}}, rd_data};
      if (rd_data > hi) begin
        hi <= rd_data;
      end
      if (rd_data < lo) begin
        lo <= rd_data;
      end
    end
  end

  assign trimmed   = sum - {{(SUM_W-SW){hi[SW-1]}}, hi} - {{(SUM_W-SW){lo[SW-1]}}, lo};
  assign rem_shift = {rem, quot[SUM_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.trim) begin
      div_cnt <= DCNT_W'(SUM_W);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trim) begin
      neg     <= trimmed[SUM_W-1];
      quot    <= trimmed[SUM_W-1] ? (~trimmed + 1'b1) : trimmed;
      rem     <= '0;
      divisor <= held_count - CNT_W'(2);
    end else if (cmd.div_step) begin
      quot <= {quot[SUM_W-2:0], rem_ge};
      rem  <= rem_ge ? CNT_W'(rem_shift - {1'b0, divisor}) : CNT_W'(rem_shift);
    end
  end

  assign signed_quot = neg ? (~quot + 1'b1) : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_mean       <= status.valid_now ? signed_quot[SW-1:0] : '0;
      res_mean_valid <= status.valid_now;
      res_fill       <= swtm_pkg::FILL_W'(held_count);
    end
  end

  always_comb begin
    status.valid_now = (32'(held_count) >= MIN_SAMPLES) && (held_count > CNT_W'(2));
    status.scan_done = (issue_cnt == held_count) && !rd_pend;
    status.div_done  = (div_cnt == '0);
    status.out_free  = !res_valid || res_ready;
  end

endmodule

`default_nettype wire

>>> hw/rtl/sliding_window_trimmed_mean_unit.sv
// Top level of the sliding window trimmed mean unit.
// Joins swtm_ctrl and swtm_dp; uses swtm_pkg for widths and structs.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_tvalid/s_tready  | s_tdata: sample
//   m_      | out | m_tvalid/m_tready  | m_tdata: mean, fill_count; m_tuser: mean_valid
//
// One item at a time. An item that yields a valid mean passes through the one-read
// window memory scan over the n samples held and the one-bit-a-cycle divider over
// SUM_W = 25 + clog2(WINDOW_DEPTH) quotient bits. An item with mean_valid low skips
// the scan and the divider. Reset clears the count and write slot.
// A waiting result does not block the next item; only its own finish waits for room.
`default_nettype none

module sliding_window_trimmed_mean_unit #(
  parameter int MIN_SAMPLES  = 8,
  parameter int WINDOW_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [23:0] sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [23:0] mean, [28:24] fill_count, [31:29] zero
  output logic             m_tuser    // [0] mean_valid
);

  swtm_pkg::cmd_t    cmd;
  swtm_pkg::status_t status;
  logic signed [swtm_pkg::SAMPLE_W-1:0] res_mean;
  logic [swtm_pkg::FILL_W-1:0]          res_fill;

  swtm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  swtm_dp #(
    .MIN_SAMPLES  (MIN_SAMPLES),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .sample         (s_tdata),
    .res_valid      (m_tvalid),
    .res_ready      (m_tready),
    .res_mean       (res_mean),
    .res_mean_valid (m_tuser),
    .res_fill       (res_fill)
  );

  assign m_tdata = {3'b000, res_fill, res_mean};

endmodule

`default_nettype wire

>>> hw/rtl/swtm_checker.sv
// Port-level checker for the sliding window trimmed mean unit.
// Bound to sliding_window_trimmed_mean_unit; sees its ports only.
`default_nettype none

module swtm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Stalled result changed or was dropped.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input taken again before the item was finished.");

  a_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[23:0] == 24'd0)
    else $error("Mean is nonzero while the result is flagged not valid.");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:29] == 3'd0)
    else $error("Padding bits of the result are not zero.");

endmodule

bind sliding_window_trimmed_mean_unit swtm_checker u_swtm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
